### hdl/rtw_pkg.sv
// shared types and constants for the relocation table walker
`timescale 1ns / 1ps

package rtw_pkg;

  // input op codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_ENTRY = 2'd2;

  // relocation entry kinds
  localparam logic [7:0] TY_NONE   = 8'd0;
  localparam logic [7:0] TY_ADDR32 = 8'd1;
  localparam logic [7:0] TY_ADDR24 = 8'd2;
  localparam logic [7:0] TY_LO     = 8'd4;
  localparam logic [7:0] TY_HI     = 8'd5;
  localparam logic [7:0] TY_HA     = 8'd6;
  localparam logic [7:0] TY_REL24  = 8'd10;
  localparam logic [7:0] TY_RNONE  = 8'd201;
  localparam logic [7:0] TY_SECT   = 8'd202;
  localparam logic [7:0] TY_STOP   = 8'd203;

  // result status codes
  localparam logic [2:0] ST_PATCHED  = 3'd0;
  localparam logic [2:0] ST_NOTHING  = 3'd1;
  localparam logic [2:0] ST_UNSUPP   = 3'd2;
  localparam logic [2:0] ST_BAD_SYM  = 3'd3;
  localparam logic [2:0] ST_BAD_POS  = 3'd4;
  localparam logic [2:0] ST_STOP     = 3'd5;

  // write sizes
  localparam logic [2:0] WB_NONE = 3'd0;
  localparam logic [2:0] WB_HALF = 3'd2;
  localparam logic [2:0] WB_WORD = 3'd4;

  // field masks
  localparam logic [31:0] MASK24  = 32'h03FF_FFFC;
  localparam logic [31:0] MASKHI  = 32'hFFFF_0000;
  localparam logic [31:0] MASKALL = 32'hFFFF_FFFF;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // one classified item handed from front to back
  typedef struct packed {
    logic        is_begin;
    logic        module_is_main;
    logic [7:0]  entry_type;
    logic [15:0] entry_offset;
    logic [31:0] entry_addend;
    logic [31:0] sect_addr;
    logic        sect_bad;
    logic [31:0] sect_sum;
  } rtw_cmd_t;

endpackage

### hdl/ppc_relocation_table_walker_core.sv
// top level of the relocation table walker
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | op, module_is_main, section_index, ...
//   out_    | output    | out_valid/out_ready  | status, target_address, patch_value, ...
//   cfg_    | input     | cfg_valid/cfg_ready  | section_count
//
// one item per cycle sustained unless back pressure stalls; an entry's result passes the
// table read stage, a queue slot, then the result register, plus queue wait under back pressure
// the section table has one valid bit per entry, so no clearing pass after reset
// the front and back stall independently through a two-entry command queue
// reset is synchronous, active low; cfg_ready is always high
`timescale 1ns / 1ps

module ppc_relocation_table_walker_core import rtw_pkg::*; #(
  parameter int SECTIONS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic        in_module_is_main,
  input  logic [7:0]  in_section_index,
  input  logic [31:0] in_section_address,
  input  logic [15:0] in_entry_offset,
  input  logic [7:0]  in_entry_type,
  input  logic [31:0] in_entry_addend,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_target_address,
  output logic [31:0] out_patch_value,
  output logic [31:0] out_field_mask,
  output logic [2:0]  out_write_bytes
);

  logic [7:0] section_count_r;
  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  rtw_cmd_t   push_cmd, pop_cmd;

  // section count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_count_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      section_count_r <= cfg_data;
    end
  end

  // accept, table and lookup
  rtw_front #(
    .SECTIONS (SECTIONS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .section_count      (section_count_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_module_is_main  (in_module_is_main),
    .in_section_index   (in_section_index),
    .in_section_address (in_section_address),
    .in_entry_offset    (in_entry_offset),
    .in_entry_type      (in_entry_type),
    .in_entry_addend    (in_entry_addend),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_cmd           (push_cmd)
  );

  // decoupling queue
  rtw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // walk and result
  rtw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (pop_valid),
    .cmd_ready          (pop_ready),
    .cmd                (pop_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_target_address (out_target_address),
    .out_patch_value    (out_patch_value),
    .out_field_mask     (out_field_mask),
    .out_write_bytes    (out_write_bytes)
  );

endmodule

### hdl/rtw_front.sv
// front end: accepts items, keeps the section table, classifies and looks up
`timescale 1ns / 1ps

module rtw_front import rtw_pkg::*; #(
  parameter int SECTIONS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  section_count,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic        in_module_is_main,
  input  logic [7:0]  in_section_index,
  input  logic [31:0] in_section_address,
  input  logic [15:0] in_entry_offset,
  input  logic [7:0]  in_entry_type,
  input  logic [31:0] in_entry_addend,
  output logic        push_valid,
  input  logic        push_ready,
  output rtw_cmd_t    push_cmd
);

  localparam int IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [8:0] SECT_LIM = 9'(SECTIONS);

  logic [31:0]         sect_mem_r [SECTIONS];
  logic [SECTIONS-1:0] sect_vld_r;

  logic             in_fire;
  logic             idx_in_range;
  logic [IDX_W-1:0] idx;
  logic             lookup_ok;

  // stage register between the accept and the queue
  logic        f_vld_r, f_vld_nxt;
  logic        f_begin_r;
  logic        f_main_r;
  logic [7:0]  f_type_r;
  logic [15:0] f_offset_r;
  logic [31:0] f_addend_r;
  logic        f_ok_r;
  logic [31:0] f_data_r;
  logic [31:0] f_sect;

  assign in_fire      = in_valid && in_ready;
  assign idx          = in_section_index[IDX_W-1:0];
  assign idx_in_range = {1'b0, in_section_index} < SECT_LIM;
  assign lookup_ok    = idx_in_range && (in_section_index < section_count)
                        && sect_vld_r[idx];

  // stage drains into the queue, so a new item fits whenever it moves on
  assign in_ready   = !f_vld_r || push_ready;
  assign push_valid = f_vld_r;

  // section table storage
  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_LOAD && idx_in_range) begin
      sect_mem_r[idx] <= in_section_address;
    end
  end

  // per-entry valid bits, an entry never loaded reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sect_vld_r <= '0;
    end else if (in_fire && in_op == OP_LOAD && idx_in_range) begin
      sect_vld_r[idx] <= 1'b1;
    end
  end

  // only begin and entry items travel on
  always_comb begin
    f_vld_nxt = f_vld_r && !push_ready;
    if (in_fire && (in_op == OP_BEGIN || in_op == OP_ENTRY)) begin
      f_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  // payload and registered table read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      f_begin_r  <= (in_op == OP_BEGIN);
      f_main_r   <= in_module_is_main;
      f_type_r   <= in_entry_type;
      f_offset_r <= in_entry_offset;
      f_addend_r <= in_entry_addend;
      f_ok_r     <= lookup_ok;
      f_data_r   <= sect_mem_r[idx];
    end
  end

  // resolved section start and symbol sum
  assign f_sect = f_ok_r ? f_data_r : 32'd0;

  always_comb begin
    push_cmd.is_begin       = f_begin_r;
    push_cmd.module_is_main = f_main_r;
    push_cmd.entry_type     = f_type_r;
    push_cmd.entry_offset   = f_offset_r;
    push_cmd.entry_addend   = f_addend_r;
    push_cmd.sect_addr      = f_sect;
    push_cmd.sect_bad       = (f_sect == 32'd0);
    push_cmd.sect_sum       = f_sect + f_addend_r;
  end

endmodule

### hdl/rtw_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module rtw_queue import rtw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  rtw_cmd_t push_cmd,
  output logic     pop_valid,
  input  logic     pop_ready,
  output rtw_cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W:0] FULL = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  rtw_cmd_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/rtw_back.sv
// back end: walk state, field computation and result register
`timescale 1ns / 1ps

module rtw_back import rtw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  rtw_cmd_t    cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_target_address,
  output logic [31:0] out_patch_value,
  output logic [31:0] out_field_mask,
  output logic [2:0]  out_write_bytes
);

  // walk state
  logic [31:0] patch_pos_r, patch_pos_nxt;
  logic        abs_r, abs_nxt;
  logic        ended_r, ended_nxt;

  // result register
  logic        out_vld_r, out_vld_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] target_r;
  logic [31:0] value_r, value_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [2:0]  bytes_r, bytes_nxt;

  logic        slot_free;
  logic        emits;
  logic        do_pop;
  logic [31:0] pos_step;
  logic [31:0] sum;
  logic [31:0] rel;
  logic [15:0] ha_half;

  assign slot_free = !out_vld_r || out_ready;
  assign emits     = !cmd.is_begin && !ended_r;
  assign cmd_ready = !emits || slot_free;
  assign do_pop    = cmd_valid && cmd_ready;

  // arithmetic for the current entry
  assign pos_step = patch_pos_r + {16'd0, cmd.entry_offset};
  assign sum      = abs_r ? cmd.entry_addend : cmd.sect_sum;
  assign rel      = sum - patch_pos_r - {16'd0, cmd.entry_offset};
  assign ha_half  = sum[31:16] + {15'd0, sum[15]};

  // walk step and result fields
  always_comb begin
    patch_pos_nxt = patch_pos_r;
    abs_nxt       = abs_r;
    ended_nxt     = ended_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    status_nxt    = ST_NOTHING;
    value_nxt     = 32'd0;
    mask_nxt      = 32'd0;
    bytes_nxt     = WB_NONE;
    if (do_pop) begin
      if (cmd.is_begin) begin
        patch_pos_nxt = 32'd0;
        abs_nxt       = cmd.module_is_main;
        ended_nxt     = 1'b0;
      end else if (!ended_r) begin
        out_vld_nxt = 1'b1;
        if (cmd.entry_type == TY_SECT && cmd.sect_bad) begin
          // position section missing aborts the walk
          ended_nxt  = 1'b1;
          status_nxt = ST_BAD_POS;
        end else if (cmd.entry_type == TY_STOP) begin
          ended_nxt  = 1'b1;
          status_nxt = ST_STOP;
        end else begin
          patch_pos_nxt = (cmd.entry_type == TY_SECT) ? cmd.sect_addr : pos_step;
          if (!abs_r && cmd.sect_bad) begin
            status_nxt = ST_BAD_SYM;
          end else begin
            status_nxt = ST_PATCHED;
            unique case (cmd.entry_type) inside
              TY_ADDR32: begin
                value_nxt = sum;
                mask_nxt  = MASKALL;
                bytes_nxt = WB_WORD;
              end
              TY_ADDR24: begin
                value_nxt = sum & MASK24;
                mask_nxt  = MASK24;
                bytes_nxt = WB_WORD;
              end
              TY_REL24: begin
                value_nxt = rel & MASK24;
                mask_nxt  = MASK24;
                bytes_nxt = WB_WORD;
              end
              TY_LO: begin
                value_nxt = {sum[15:0], 16'd0};
                mask_nxt  = MASKHI;
                bytes_nxt = WB_HALF;
              end
              TY_HI: begin
                value_nxt = sum & MASKHI;
                mask_nxt  = MASKHI;
                bytes_nxt = WB_HALF;
              end
              TY_HA: begin
                value_nxt = {ha_half, 16'd0};
                mask_nxt  = MASKHI;
                bytes_nxt = WB_HALF;
              end
              TY_NONE, TY_RNONE, TY_SECT: begin
                status_nxt = ST_NOTHING;
              end
              default: begin
                status_nxt = ST_UNSUPP;
              end
            endcase
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_pos_r <= 32'd0;
      abs_r       <= 1'b0;
      ended_r     <= 1'b1;
      out_vld_r   <= 1'b0;
    end else begin
      patch_pos_r <= patch_pos_nxt;
      abs_r       <= abs_nxt;
      ended_r     <= ended_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // result payload, loaded when an entry emits
  always_ff @(posedge clk) begin
    if (do_pop && emits) begin
      status_r <= status_nxt;
      target_r <= patch_pos_nxt;
      value_r  <= value_nxt;
      mask_r   <= mask_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = status_r;
  assign out_target_address = target_r;
  assign out_patch_value    = value_r;
  assign out_field_mask     = mask_r;
  assign out_write_bytes    = bytes_r;

endmodule

### bench/tb_ppc_relocation_table_walker_core.sv
// self-checking testbench for the relocation table walker core
`timescale 1ns / 1ps

module tb_ppc_relocation_table_walker_core;
  import rtw_pkg::*;

  localparam int SECTIONS      = 128;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 250;
  localparam int RECENT_DEPTH  = 16;

  // codes the block has no name for
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [7:0] TY_UNKNOWN     = 8'd3;
  localparam logic [7:0] TY_UNKNOWN_TOP = 8'd255;

  // one input item
  typedef struct {
    logic [1:0]  op;
    logic        main_mod;
    logic [7:0]  sect;
    logic [31:0] sect_addr;
    logic [15:0] offset;
    logic [7:0]  kind;
    logic [31:0] addend;
  } reloc_item_t;

  // one result item
  typedef struct {
    logic [2:0]  status;
    logic [31:0] target;
    logic [31:0] value;
    logic [31:0] mask;
    logic [2:0]  bytes;
  } patch_t;

  logic        clk;
  logic        rst_n              = 1'b0;
  logic        cfg_valid          = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data           = '0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op              = OP_LOAD;
  logic        in_module_is_main  = 1'b0;
  logic [7:0]  in_section_index   = '0;
  logic [31:0] in_section_address = '0;
  logic [15:0] in_entry_offset    = '0;
  logic [7:0]  in_entry_type      = TY_NONE;
  logic [31:0] in_entry_addend    = '0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_target_address;
  logic [31:0] out_patch_value;
  logic [31:0] out_field_mask;
  logic [2:0]  out_write_bytes;

  // walker state as the bench sees it
  logic [31:0] sect_addr [SECTIONS];
  logic [31:0] patch_pos   = '0;
  logic        abs_symbols = 1'b0;
  logic        walk_done   = 1'b1;
  logic [7:0]  sect_count  = '0;

  patch_t pending_patches [$];
  patch_t seen_want;
  int     loaded_idx [$];
  int     errors         = 0;
  int     items_sent     = 0;
  int     cycle_count    = 0;
  int     burst_left     = 0;
  bit     steady         = 1'b0;
  int     hold_off_asked = 0;
  int     hold_off_seen  = 0;
  int     hold_left      = 0;
  int     stall_mode     = 0;
  int     stall_left     = 0;

  ppc_relocation_table_walker_core #(
    .SECTIONS(SECTIONS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_module_is_main(in_module_is_main),
    .in_section_index(in_section_index),
    .in_section_address(in_section_address),
    .in_entry_offset(in_entry_offset),
    .in_entry_type(in_entry_type),
    .in_entry_addend(in_entry_addend),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_target_address(out_target_address),
    .out_patch_value(out_patch_value),
    .out_field_mask(out_field_mask),
    .out_write_bytes(out_write_bytes)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_ppc_relocation_table_walker_core: FAIL");
      $finish;
    end
  end

  // section start, zero when out of range or not counted
  function automatic logic [31:0] sect_base(input logic [7:0] idx);
    if (int'(idx) >= int'(sect_count) || int'(idx) >= SECTIONS) return '0;
    return sect_addr[idx[6:0]];
  endfunction

  // update walker state for an accepted item and queue its patch, if any
  function automatic void predict_patch(input reloc_item_t it);
    patch_t      r;
    logic [31:0] s;
    logic [31:0] sum;
    logic        done;
    case (it.op)
      OP_LOAD: begin
        if (int'(it.sect) < SECTIONS) sect_addr[it.sect[6:0]] = it.sect_addr;
      end
      OP_BEGIN: begin
        patch_pos   = '0;
        abs_symbols = it.main_mod;
        walk_done   = 1'b0;
      end
      OP_ENTRY: begin
        if (!walk_done) begin
          r    = '{ST_PATCHED, 32'd0, 32'd0, 32'd0, WB_NONE};
          done = 1'b0;
          // position step
          if (it.kind == TY_SECT) begin
            s = sect_base(it.sect);
            if (s == '0) begin
              walk_done = 1'b1;
              r.status  = ST_BAD_POS;
              done      = 1'b1;
            end else begin
              patch_pos = s;
            end
          end else if (it.kind == TY_STOP) begin
            walk_done = 1'b1;
            r.status  = ST_STOP;
            done      = 1'b1;
          end else begin
            patch_pos = patch_pos + 32'(it.offset);
          end
          // symbol base, checked before the kind
          if (!done) begin
            if (abs_symbols) begin
              s = '0;
            end else begin
              s = sect_base(it.sect);
              if (s == '0) begin
                r.status = ST_BAD_SYM;
                done     = 1'b1;
              end
            end
          end
          // field bits
          if (!done) begin
            sum = s + it.addend;
            case (it.kind)
              TY_ADDR32: begin
                r.value = sum;
                r.mask  = MASKALL;
                r.bytes = WB_WORD;
              end
              TY_ADDR24: begin
                r.value = sum & MASK24;
                r.mask  = MASK24;
                r.bytes = WB_WORD;
              end
              TY_REL24: begin
                r.value = (sum - patch_pos) & MASK24;
                r.mask  = MASK24;
                r.bytes = WB_WORD;
              end
              TY_LO: begin
                r.value = {sum[15:0], 16'h0000};
                r.mask  = MASKHI;
                r.bytes = WB_HALF;
              end
              TY_HI: begin
                r.value = sum & MASKHI;
                r.mask  = MASKHI;
                r.bytes = WB_HALF;
              end
              TY_HA: begin
                r.value = {sum[31:16] + {15'd0, sum[15]}, 16'h0000};
                r.mask  = MASKHI;
                r.bytes = WB_HALF;
              end
              TY_NONE, TY_RNONE, TY_SECT: r.status = ST_NOTHING;
              default: r.status = ST_UNSUPP;
            endcase
          end
          r.target = patch_pos;
          pending_patches.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // item builders; fields the op does not use carry random bits
  function automatic reloc_item_t noise_item();
    reloc_item_t it;
    it.op        = 2'($urandom_range(OP_LOAD, OP_UNUSED));
    it.main_mod  = 1'($urandom);
    it.sect      = 8'($urandom);
    it.sect_addr = $urandom;
    it.offset    = 16'($urandom);
    it.kind      = 8'($urandom);
    it.addend    = $urandom;
    return it;
  endfunction

  function automatic reloc_item_t mk_load(input logic [7:0] idx, input logic [31:0] addr);
    reloc_item_t it;
    it           = noise_item();
    it.op        = OP_LOAD;
    it.sect      = idx;
    it.sect_addr = addr;
    return it;
  endfunction

  function automatic reloc_item_t mk_begin(input logic main_mod);
    reloc_item_t it;
    it          = noise_item();
    it.op       = OP_BEGIN;
    it.main_mod = main_mod;
    return it;
  endfunction

  function automatic reloc_item_t mk_entry(input logic [7:0] kind, input logic [7:0] idx,
                                           input logic [15:0] offset, input logic [31:0] addend);
    reloc_item_t it;
    it        = noise_item();
    it.op     = OP_ENTRY;
    it.kind   = kind;
    it.sect   = idx;
    it.offset = offset;
    it.addend = addend;
    return it;
  endfunction

  // random choices for walks
  function automatic int count_span();
    if (sect_count == '0 || int'(sect_count) > SECTIONS) return SECTIONS;
    return int'(sect_count);
  endfunction

  function automatic logic [7:0] pick_sect();
    if (loaded_idx.size() != 0 && $urandom_range(0, 1) == 1)
      return 8'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
    if (sect_count == '0 || $urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(0, count_span() - 1));
  endfunction

  function automatic logic [7:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 13) return TY_ADDR32;
    if (r < 26) return TY_ADDR24;
    if (r < 39) return TY_LO;
    if (r < 52) return TY_HI;
    if (r < 65) return TY_HA;
    if (r < 78) return TY_REL24;
    if (r < 84) return TY_SECT;
    if (r < 88) return TY_NONE;
    if (r < 91) return TY_RNONE;
    if (r < 93) return TY_STOP;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_offset();
    if ($urandom_range(0, 1) == 1) return 16'($urandom_range(0, 64));
    return 16'($urandom);
  endfunction

  // send one item in random bursts, then record it once accepted
  task automatic send_item(input reloc_item_t it);
    int idle;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle       = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (idle) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid           <= 1'b1;
    in_op              <= it.op;
    in_module_is_main  <= it.main_mod;
    in_section_index   <= it.sect;
    in_section_address <= it.sect_addr;
    in_entry_offset    <= it.offset;
    in_entry_type      <= it.kind;
    in_entry_addend    <= it.addend;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_patch(it);
  endtask

  // stop sending and let every result and any trailing work finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_patches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_section_count(input logic [7:0] count);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    sect_count = count;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // loads, a begin, entries and usually a closing stop
  task automatic run_walk(input int n_entries, input bit unfinished);
    int          i;
    int          n_loads;
    logic [7:0]  idx;
    logic [31:0] addr;
    n_loads = $urandom_range(0, 4);
    for (i = 0; i < n_loads; i++) begin
      idx  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, count_span() - 1));
      addr = ($urandom_range(0, 11) == 0) ? 32'd0 : 32'($urandom);
      if (int'(idx) < SECTIONS && addr != '0) begin
        loaded_idx.push_back(int'(idx));
        if (loaded_idx.size() > RECENT_DEPTH) void'(loaded_idx.pop_front());
      end
      send_item(mk_load(idx, addr));
    end
    send_item(mk_begin($urandom_range(0, 3) == 0));
    for (i = 0; i < n_entries; i++)
      send_item(mk_entry(pick_kind(), pick_sect(), pick_offset(), $urandom));
    if (!unfinished) send_item(mk_entry(TY_STOP, pick_sect(), pick_offset(), $urandom));
  endtask

  // every kind, the range limits and the ignored cases
  task automatic test_directed_entries();
    // entry before any begin is dropped
    send_item(mk_entry(TY_ADDR32, 8'd0, 16'h0004, 32'h0000_0000));
    write_section_count(8'd4);
    send_item(mk_load(8'd0, 32'h8000_1000));
    send_item(mk_load(8'd1, 32'h0000_7FF0));
    send_item(mk_load(8'd2, 32'h0000_0000));
    send_item(mk_load(8'd3, 32'hFFFF_8000));
    // load beyond the table is ignored
    send_item(mk_load(8'd200, 32'hDEAD_BEEF));
    begin_unused: begin
      reloc_item_t it;
      it    = noise_item();
      it.op = OP_UNUSED;
      send_item(it);
    end
    send_item(mk_begin(1'b0));
    send_item(mk_entry(TY_ADDR32, 8'd0, 16'h0010, 32'h0000_0123));
    send_item(mk_entry(TY_ADDR24, 8'd3, 16'h0004, 32'hFFFF_FFFF));
    // sum 0x8000 exercises the high-adjust carry
    send_item(mk_entry(TY_LO, 8'd1, 16'h0002, 32'h0000_0010));
    send_item(mk_entry(TY_HI, 8'd1, 16'h0002, 32'h1234_0000));
    send_item(mk_entry(TY_HA, 8'd1, 16'h0002, 32'h0000_0010));
    send_item(mk_entry(TY_REL24, 8'd0, 16'h0004, 32'h0000_0000));
    send_item(mk_entry(TY_NONE, 8'd0, 16'h0000, 32'h0000_0000));
    send_item(mk_entry(TY_RNONE, 8'd0, 16'h0001, 32'h0000_0000));
    send_item(mk_entry(TY_UNKNOWN_TOP, 8'd0, 16'h0001, 32'h0000_0000));
    send_item(mk_entry(TY_UNKNOWN, 8'd0, 16'h0001, 32'h0000_0000));
    // zero section and index past the count both lack a symbol base
    send_item(mk_entry(TY_ADDR32, 8'd2, 16'h0001, 32'h0000_0000));
    send_item(mk_entry(TY_ADDR32, 8'd5, 16'h0001, 32'h0000_0000));
    send_item(mk_entry(TY_SECT, 8'd3, 16'h1234, 32'h0000_0000));
    // position wraps past the top of memory
    send_item(mk_entry(TY_ADDR32, 8'd0, 16'hFFFF, 32'h0000_0000));
    // jump to a zero section aborts the walk
    send_item(mk_entry(TY_SECT, 8'd2, 16'h0000, 32'h0000_0000));
    send_item(mk_entry(TY_ADDR32, 8'd0, 16'h0004, 32'h0000_0000));
    // absolute symbols ignore the section
    send_item(mk_begin(1'b1));
    send_item(mk_entry(TY_HA, 8'd255, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk_entry(TY_STOP, 8'd0, 16'h0000, 32'h0000_0000));
    send_item(mk_entry(TY_ADDR32, 8'd0, 16'h0004, 32'h0000_0000));
  endtask

  // receiver holds off while a long walk streams in
  task automatic test_output_holdoff();
    wait_idle();
    hold_off_asked++;
    steady = 1'b1;
    run_walk(40, 1'b0);
    steady = 1'b0;
  endtask

  // random walks under several section counts
  task automatic test_config_sweep();
    logic [7:0] counts [6];
    int         p;
    int         start;
    int         r;
    counts = '{8'd128, 8'd0, 8'd255, 8'($urandom_range(2, 127)), 8'd1, 8'd128};
    for (p = 0; p < 6; p++) begin
      write_section_count(counts[p]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          repeat ($urandom_range(1, 4)) send_item(noise_item());
        end else begin
          run_walk($urandom_range(1, 20), r == 1);
        end
      end
    end
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_seen != hold_off_asked) begin
      hold_off_seen = hold_off_asked;
      hold_left     = HOLD_CYCLES;
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 4) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_patches.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual status %0d target %h",
                 $time, out_status, out_target_address);
      end else begin
        seen_want = pending_patches.pop_front();
        check_field("status", 32'(seen_want.status), 32'(out_status));
        check_field("target_address", seen_want.target, out_target_address);
        check_field("patch_value", seen_want.value, out_patch_value);
        check_field("field_mask", seen_want.mask, out_field_mask);
        check_field("write_bytes", 32'(seen_want.bytes), 32'(out_write_bytes));
      end
    end
  end

  // test sequence
  initial begin
    for (int i = 0; i < SECTIONS; i++) sect_addr[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_entries();
    test_output_holdoff();
    test_config_sweep();
    wait_idle();
    if (errors == 0) begin
      $display("tb_ppc_relocation_table_walker_core: PASS");
    end else begin
      $display("tb_ppc_relocation_table_walker_core: FAIL");
    end
    $finish;
  end

endmodule
